@@ rtl/pal_pkg.sv @@
// shared types and constants for the positional array list
package pal_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CMP_W    = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RD_POS  = 2'd0,
    RD_TOP  = 2'd1,
    RD_PREV = 2'd2,
    RD_NEXT = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_UP   = 2'd0,
    WR_DOWN = 2'd1,
    WR_PUT  = 2'd2
  } wr_sel_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] position;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] removed_value;
    logic [7:0] count;
    logic       empty_res;
    logic       full_res;
  } res_t;

  typedef struct packed {
    logic    latch_req;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    grab_removed;
    logic    set_status;
    status_e status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       ins_bad;
    logic       del_bad;
    logic       ins_at_end;
    logic       at_pos;
    logic       more;
    logic       out_busy;
  } stat_t;

endpackage

@@ rtl/pal_ram.sv @@
// generic simple dual-port ram with registered read
module pal_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pal_ctrl.sv @@
// sequencer for append, insert and delete requests
module pal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pal_pkg::stat_t stat_i,
  output pal_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_UP     = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_DCAP   = 3'd4;
  localparam logic [2:0] S_DMV    = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.rd_sel       = pal_pkg::RD_POS;
    cmd_o.wr_sel       = pal_pkg::WR_PUT;
    cmd_o.status       = pal_pkg::ST_DONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_CHECK: begin
        case (stat_i.kind)
          pal_pkg::KIND_APPEND, pal_pkg::KIND_INSERT: begin
            if (stat_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = pal_pkg::ST_FULL;
              state_d          = S_RESULT;
            end else if (stat_i.ins_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = pal_pkg::ST_BADPOS;
              state_d          = S_RESULT;
            end else if (stat_i.ins_at_end) begin
              state_d = S_PUT;
            end else begin
              // start moving from the last element downwards
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = pal_pkg::RD_TOP;
              state_d      = S_UP;
            end
          end
          pal_pkg::KIND_DELETE: begin
            if (stat_i.del_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = pal_pkg::ST_BADPOS;
              state_d          = S_RESULT;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = pal_pkg::RD_POS;
              state_d      = S_DCAP;
            end
          end
          default: begin
            state_d = S_RESULT;
          end
        endcase
      end
      S_UP: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = pal_pkg::WR_UP;
        if (stat_i.at_pos) begin
          state_d = S_PUT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = pal_pkg::RD_PREV;
        end
      end
      S_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = pal_pkg::WR_PUT;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_RESULT;
      end
      S_DCAP: begin
        cmd_o.grab_removed = 1'b1;
        if (stat_i.more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = pal_pkg::RD_NEXT;
          state_d      = S_DMV;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RESULT;
        end
      end
      S_DMV: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = pal_pkg::WR_DOWN;
        if (stat_i.more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = pal_pkg::RD_NEXT;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/pal_datapath.sv @@
// element store, count, shift pointer and result register
module pal_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pal_pkg::req_t  in_req_i,
  input  pal_pkg::cmd_t  cmd_i,
  output pal_pkg::stat_t stat_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pal_pkg::res_t  out_res_o
);

  localparam int unsigned CNT_W  = pal_pkg::CNT_W;
  localparam int unsigned ADDR_W = pal_pkg::ADDR_W;
  localparam int unsigned CMP_W  = pal_pkg::CMP_W;
  localparam int unsigned DATA_W = pal_pkg::DATA_W;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CMP_W-1:0]  pos_q;
  logic [1:0]        kind_q;
  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] removed_q;
  logic [1:0]        status_q;
  logic              out_valid_q, out_valid_d;
  pal_pkg::res_t     out_res_q;

  logic [CNT_W-1:0]  ptr_inc, ptr_dec, rd_addr;
  logic [CMP_W-1:0]  count_ext;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata, rdata;

  assign ptr_inc   = ptr_q + CNT_W'(1);
  assign ptr_dec   = ptr_q - CNT_W'(1);
  assign count_ext = CMP_W'(count_q);

  always_comb begin
    case (cmd_i.rd_sel)
      pal_pkg::RD_POS:  rd_addr = pos_q[CNT_W-1:0];
      pal_pkg::RD_TOP:  rd_addr = count_q - CNT_W'(1);
      pal_pkg::RD_PREV: rd_addr = ptr_dec;
      pal_pkg::RD_NEXT: rd_addr = ptr_inc;
      default:          rd_addr = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      pal_pkg::WR_UP: begin
        waddr = ptr_inc[ADDR_W-1:0];
        wdata = rdata;
      end
      pal_pkg::WR_DOWN: begin
        waddr = ptr_dec[ADDR_W-1:0];
        wdata = rdata;
      end
      pal_pkg::WR_PUT: begin
        waddr = pos_q[ADDR_W-1:0];
        wdata = value_q;
      end
      default: begin
        waddr = pos_q[ADDR_W-1:0];
        wdata = value_q;
      end
    endcase
  end

  pal_ram #(
    .WIDTH(DATA_W),
    .DEPTH(pal_pkg::CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr[ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // pointer follows the address last read
  assign ptr_d = cmd_i.rd_en ? rd_addr : ptr_q;

  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.latch_req) begin
      kind_q    <= in_req_i.kind;
      value_q   <= in_req_i.value;
      removed_q <= '0;
      status_q  <= pal_pkg::ST_DONE;
      // append is an insert at the current count
      if (in_req_i.kind == pal_pkg::KIND_APPEND) begin
        pos_q <= count_ext;
      end else begin
        pos_q <= CMP_W'(in_req_i.position);
      end
    end
    if (cmd_i.grab_removed) begin
      removed_q <= rdata;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.out_load) begin
      out_res_q.status        <= status_q;
      out_res_q.removed_value <= removed_q;
      out_res_q.count         <= count_ext[7:0];
      out_res_q.empty_res     <= (count_q == '0);
      out_res_q.full_res      <= (count_q == CNT_W'(pal_pkg::CAPACITY));
    end
  end

  assign stat_o.kind       = kind_q;
  assign stat_o.full       = (count_q == CNT_W'(pal_pkg::CAPACITY));
  assign stat_o.ins_bad    = (pos_q > count_ext);
  assign stat_o.del_bad    = (pos_q >= count_ext);
  assign stat_o.ins_at_end = (pos_q == count_ext);
  assign stat_o.at_pos     = (ptr_q == pos_q[CNT_W-1:0]);
  assign stat_o.more       = (ptr_inc < count_q);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

@@ rtl/positional_array_list_core.sv @@
// top level of the positional array list engine
//
// Request channel in_valid_i/in_ready_o carries one operation in in_req_i:
// append, insert at a position or delete at a position. Each request gives
// exactly one result on out_valid_o/out_ready_i in out_res_o: status,
// removed byte, element count and the empty and full flags.
// Requests are handled one at a time. A rejected request, an unused kind,
// an append and an insert at the end move no element. An insert at position
// p below the count moves the count - p elements from p upwards up by one,
// and a delete at p moves the count - p - 1 elements above p down by one,
// one element moved per cycle through the one read port and one write port
// of the element ram. The next request is accepted at the earliest in the
// cycle after a result is loaded into the output register.
// The output register holds a result while the receiver stalls; the next
// request may be accepted and worked on, but its result waits until the
// held one is taken.
// Reset clears the element count and the result valid flag, leaving an empty
// list; the element ram needs no clearing pass.
module positional_array_list_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pal_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pal_pkg::res_t out_res_o
);

  pal_pkg::cmd_t  cmd;
  pal_pkg::stat_t stat;

  pal_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pal_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

endmodule

@@ rtl/pal_checker.sv @@
// port-level checks for the positional array list, bound to the top level
module pal_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input pal_pkg::req_t in_req_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input pal_pkg::res_t out_res_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_res_o.empty_res && out_res_o.full_res))
    else $error("list reported both empty and full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.status == pal_pkg::ST_FULL) |-> out_res_o.full_res)
    else $error("full status on a list that is not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_res_o.removed_value != 8'd0)
      |-> (out_res_o.status == pal_pkg::ST_DONE) && !out_res_o.full_res)
    else $error("removed byte on a failed request or full list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pal_pkg::CAPACITY < 256)
      |-> (out_res_o.empty_res == (out_res_o.count == 8'd0)))
    else $error("empty flag disagrees with count");

endmodule

bind positional_array_list_core pal_checker u_pal_checker (.*);
